// File: rtl/ijpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IISPH Jacobi pressure update: shared definitions
// Widths, register indexes, item codes, sequencer states and the divider
// status bundle used by the pressure update block and its divider.
// ----------------------------------------------------------------------------
package ijpu_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_W  = 31;
  localparam int DATA_W = 32;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = 64;
  localparam int DEN_W  = 32;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_TIME_STEP    = 2'd0;
  localparam logic [IDX_W-1:0] REG_RELAXATION   = 2'd1;
  localparam logic [IDX_W-1:0] REG_REST_DENSITY = 2'd2;

  localparam logic [CFG_W-1:0] TIME_STEP_RST    = 31'd66;
  localparam logic [CFG_W-1:0] RELAXATION_RST   = 31'd32768;
  localparam logic [CFG_W-1:0] REST_DENSITY_RST = 31'd65536000;

  localparam logic ACT_HEADER = 1'b0;
  localparam logic ACT_TERM   = 1'b1;

  localparam logic signed [PROD_W-1:0] WIDE_I32_MAX = 66'sh0_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] WIDE_I32_MIN = -66'sh0_8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_MUL,
    ST_T_ACC,
    ST_M_MUL,
    ST_M_ACC,
    ST_R_DT,
    ST_R_DT2,
    ST_R_AP,
    ST_R_APS,
    ST_R_NUM,
    ST_R_NUMS,
    ST_DERR,
    ST_DERR_W,
    ST_STEP,
    ST_STEP_W,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/ijpu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IISPH Jacobi pressure update: iterative divider
// Unsigned restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ijpu_div
  import ijpu_pkg::*;
#(
  parameter int DVD_W = MUL_W + FRAC_BITS_DEF,
  parameter int DIV_W = DEN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output div_stat_t        stat
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] den;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[DVD_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], fits};
      rem <= fits ? DIV_W'(trial - {1'b0, den}) : trial[DIV_W-1:0];
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: rtl/iisph_jacobi_pressure_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IISPH relaxed Jacobi pressure update
// Accumulates the neighbour terms of one particle and computes its signed
// AP value and density error and its relaxed, clamped unsigned new pressure in fixed point.
// ----------------------------------------------------------------------------
// One 33 x 33 bit multiplier with a registered product and one restoring
// divider are shared under a small sequencer, and the block takes one
// transaction at a time. A header or a self entry is taken in the idle state;
// a neighbour term runs three products and their accumulation, then the mass
// product and the saturating add. The transaction marked last then uses the
// multiplier for dt squared, the AP value and the relaxed numerator, and up
// to two divisions (density error, then pressure step), before the result is
// loaded into the output register; the sequencer waits there while the
// receiver holds off. A new transaction is taken while a result still waits
// in that register.
module iisph_jacobi_pressure_update
  import ijpu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     action,
  input  logic signed [DATA_W-1:0] vec_x,
  input  logic signed [DATA_W-1:0] vec_y,
  input  logic signed [DATA_W-1:0] vec_z,
  input  logic signed [DATA_W-1:0] grad_x,
  input  logic signed [DATA_W-1:0] grad_y,
  input  logic signed [DATA_W-1:0] grad_z,
  input  logic signed [DATA_W-1:0] scalar_a,
  input  logic signed [DATA_W-1:0] scalar_b,
  input  logic signed [DATA_W-1:0] scalar_c,
  input  logic                     is_self,
  input  logic                     last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [CFG_W-1:0]         new_pressure,
  output logic signed [DATA_W-1:0] density_error,
  output logic signed [DATA_W-1:0] ap_value
);

  localparam int DOT_W = PROD_W - FRAC_BITS + 2;
  localparam int DVD_W = MUL_W + FRAC_BITS;
  localparam int PW    = DVD_W + 2;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    r = x[DATA_W-1:0];
    if (x > WIDE_I32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < WIDE_I32_MIN) begin
      r = 32'sh8000_0000;
    end
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] clamp_p(input logic signed [PW-1:0] x);
    logic [CFG_W-1:0] r;
    r = x[CFG_W-1:0];
    if (x[PW-1]) begin
      r = '0;
    end else if (x[PW-2:CFG_W] != '0) begin
      r = '1;
    end
    return r;
  endfunction

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0] time_step;
  logic [CFG_W-1:0] relaxation;
  logic [CFG_W-1:0] rest_density;

  logic signed [DATA_W-1:0] own_accel [3];
  logic signed [DATA_W-1:0] source_term;
  logic signed [DATA_W-1:0] diagonal;
  logic signed [DATA_W-1:0] old_pressure;
  logic signed [SUM_W-1:0]  neighbor_sum;

  logic signed [DATA_W-1:0] vec_r  [3];
  logic signed [DATA_W-1:0] grad_r [3];
  logic signed [DATA_W-1:0] mass_r;
  logic                     last_r;
  logic [1:0]               k;
  logic signed [DOT_W-1:0]  dot_acc;
  logic [CFG_W-1:0]         dt2;
  logic signed [DATA_W-1:0] ap;
  logic signed [DATA_W-1:0] num;
  logic signed [DATA_W-1:0] derr;
  logic [CFG_W-1:0]         press;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;

  logic signed [DATA_W-1:0] dot_sat;
  logic signed [DATA_W-1:0] s_sat;
  logic [SUM_W:0]           sum_add;
  logic [SUM_W-1:0]         sum_sat;
  logic signed [MUL_W-1:0]  err;
  logic [MUL_W-1:0]         err_mag;
  logic                     num_neg;
  logic [DEN_W-1:0]         num_mag;
  logic [DEN_W-1:0]         diag_mag;
  logic                     step_neg;

  logic                     accept;
  logic                     out_free;
  logic                     div_start;
  logic [DVD_W-1:0]         div_dividend;
  logic [DEN_W-1:0]         div_divisor;
  logic [DVD_W-1:0]         div_quo;
  div_stat_t                div_stat;

  logic signed [DATA_W-1:0] derr_div;
  logic signed [PW-1:0]     step_s;
  logic signed [PW-1:0]     p_sum;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Shared multiplier with a registered product.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_T_MUL: begin
        mul_a = MUL_W'(own_accel[k]) - MUL_W'(vec_r[k]);
        mul_b = MUL_W'(grad_r[k]);
      end
      ST_M_MUL: begin
        mul_a = MUL_W'(mass_r);
        mul_b = MUL_W'(dot_sat);
      end
      ST_R_DT: begin
        mul_a = {2'b00, time_step};
        mul_b = {2'b00, time_step};
      end
      ST_R_AP: begin
        mul_a = {2'b00, dt2};
        mul_b = MUL_W'(s_sat);
      end
      ST_R_NUM: begin
        mul_a = {2'b00, relaxation};
        mul_b = MUL_W'(source_term) - MUL_W'(ap);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign prod_sh = prod >>> FRAC_BITS;
  assign dot_sat = sat32(PROD_W'(dot_acc));
  assign s_sat   = sat32(PROD_W'(neighbor_sum));

  assign sum_add = {neighbor_sum[SUM_W-1], neighbor_sum} + prod_sh[SUM_W:0];
  always_comb begin
    sum_sat = sum_add[SUM_W-1:0];
    if (sum_add[SUM_W] != sum_add[SUM_W-1]) begin
      sum_sat = sum_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  assign err      = MUL_W'(ap) - MUL_W'(source_term);
  assign err_mag  = err[MUL_W-1] ? MUL_W'(-err) : err;
  assign num_neg  = num[DATA_W-1];
  assign num_mag  = num_neg ? DEN_W'(-num) : DEN_W'(num);
  assign diag_mag = diagonal[DATA_W-1] ? DEN_W'(-diagonal) : DEN_W'(diagonal);
  assign step_neg = num_neg ^ diagonal[DATA_W-1];

  // The divider serves the density error first and the pressure step second.
  always_comb begin
    div_dividend = {1'b0, num_mag, {FRAC_BITS{1'b0}}};
    div_divisor  = diag_mag;
    if (state == ST_DERR) begin
      div_dividend = {err_mag, {FRAC_BITS{1'b0}}};
      div_divisor  = {1'b0, rest_density};
    end
  end

  ijpu_div #(
    .DVD_W(DVD_W),
    .DIV_W(DEN_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .quotient(div_quo),
    .stat    (div_stat)
  );

  always_comb begin
    if (err[MUL_W-1]) begin
      derr_div = (div_quo > DVD_W'(64'h8000_0000)) ? 32'sh8000_0000 :
                 -$signed(div_quo[DATA_W-1:0]);
    end else begin
      derr_div = (div_quo > DVD_W'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF :
                 $signed(div_quo[DATA_W-1:0]);
    end
  end

  assign step_s = $signed({2'b00, div_quo});
  assign p_sum  = PW'(old_pressure) + (step_neg ? -step_s : step_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (action == ACT_TERM && !is_self) begin
            state_next = ST_T_MUL;
          end else if (last) begin
            state_next = ST_R_DT;
          end
        end
      end
      ST_T_MUL:  state_next = ST_T_ACC;
      ST_T_ACC:  state_next = (k == 2'd2) ? ST_M_MUL : ST_T_MUL;
      ST_M_MUL:  state_next = ST_M_ACC;
      ST_M_ACC:  state_next = last_r ? ST_R_DT : ST_IDLE;
      ST_R_DT:   state_next = ST_R_DT2;
      ST_R_DT2:  state_next = ST_R_AP;
      ST_R_AP:   state_next = ST_R_APS;
      ST_R_APS:  state_next = ST_R_NUM;
      ST_R_NUM:  state_next = ST_R_NUMS;
      ST_R_NUMS: state_next = ST_DERR;
      ST_DERR: begin
        if (rest_density == '0) begin
          state_next = ST_STEP;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DERR_W;
        end
      end
      ST_DERR_W: begin
        if (div_stat.done) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (diagonal == '0) begin
          state_next = ST_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_STEP_W;
        end
      end
      ST_STEP_W: begin
        if (div_stat.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step    <= TIME_STEP_RST;
      relaxation   <= RELAXATION_RST;
      rest_density <= REST_DENSITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP:    time_step    <= cfg_data;
        REG_RELAXATION:   relaxation   <= cfg_data;
        REG_REST_DENSITY: rest_density <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_accel[0] <= '0;
      own_accel[1] <= '0;
      own_accel[2] <= '0;
      source_term  <= '0;
      diagonal     <= '0;
      old_pressure <= '0;
      neighbor_sum <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept && action == ACT_HEADER) begin
        own_accel[0] <= vec_x;
        own_accel[1] <= vec_y;
        own_accel[2] <= vec_z;
        source_term  <= scalar_a;
        diagonal     <= scalar_b;
        old_pressure <= scalar_c;
        neighbor_sum <= '0;
      end
      if (state == ST_M_ACC) begin
        neighbor_sum <= sum_sat;
      end
      if (state == ST_OUT && out_free) begin
        out_valid    <= 1'b1;
        neighbor_sum <= '0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        vec_r[0]  <= vec_x;
        vec_r[1]  <= vec_y;
        vec_r[2]  <= vec_z;
        grad_r[0] <= grad_x;
        grad_r[1] <= grad_y;
        grad_r[2] <= grad_z;
        mass_r    <= scalar_a;
        last_r    <= last;
        k         <= '0;
        dot_acc   <= '0;
      end
      ST_T_ACC: begin
        dot_acc <= dot_acc + prod_sh[DOT_W-1:0];
        k       <= k + 1'b1;
      end
      ST_R_DT2: begin
        dt2 <= (prod_sh > WIDE_I32_MAX) ? '1 : prod_sh[CFG_W-1:0];
      end
      ST_R_APS: begin
        ap <= sat32(prod_sh);
      end
      ST_R_NUMS: begin
        num <= sat32(prod_sh);
      end
      ST_DERR: begin
        if (err[MUL_W-1]) begin
          derr <= 32'sh8000_0000;
        end else if (err != '0) begin
          derr <= 32'sh7FFF_FFFF;
        end else begin
          derr <= '0;
        end
      end
      ST_DERR_W: begin
        derr <= derr_div;
      end
      ST_STEP: begin
        press <= clamp_p(PW'(old_pressure));
      end
      ST_STEP_W: begin
        press <= clamp_p(p_sum);
      end
      ST_OUT: begin
        if (out_free) begin
          new_pressure  <= press;
          density_error <= derr;
          ap_value      <= ap;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the IISPH Jacobi pressure update block
// Feeds particle headers and neighbour terms through the valid/ready input
// channel and checks every result transaction against expected values, taken
// from the table or from a fixed point model of the relaxed Jacobi pressure
// step. It covers several register settings with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb;
  import ijpu_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 2 * FRAC + 120;
  localparam int IDLE_LIMIT = 5000;
  localparam int PHASE_ITEMS = 360;
  localparam int HOLD_CYCLES = 600;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [DATA_W-1:0] I32_LO = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] I32_HI = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] ONE = 32'sh0001_0000;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

  typedef struct {
    logic [CFG_W-1:0]         pressure;
    logic signed [DATA_W-1:0] derr;
    logic signed [DATA_W-1:0] ap;
  } pressure_res_t;

  typedef struct {
    logic                     act;
    logic signed [DATA_W-1:0] vx, vy, vz, gx, gy, gz, sa, sb, sc;
    logic                     self_ent;
    logic                     lst;
    bit                       typed;
    pressure_res_t            want;
  } particle_item_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_we;
  logic [IDX_W-1:0]         cfg_index;
  logic [CFG_W-1:0]         cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic                     out_valid;
  logic                     out_ready;
  logic [CFG_W-1:0]         new_pressure;
  logic signed [DATA_W-1:0] density_error;
  logic signed [DATA_W-1:0] ap_value;
  particle_item_t           cur;

  logic [CFG_W-1:0] m_dt, m_omega, m_rho;
  longint           m_own [3];
  longint           m_src, m_diag, m_old, m_sum;

  pressure_res_t expected_pressure_q [$];
  int            error_count = 0;
  int            items_accepted = 0;
  int            results_seen = 0;
  int            xfer_count = 0;
  int            burst_left;
  bit            gaps_on;
  bit            mon_emits;
  pressure_res_t mon_res;
  pressure_res_t mon_want;

  iisph_jacobi_pressure_update uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (cur.act),
    .vec_x        (cur.vx),
    .vec_y        (cur.vy),
    .vec_z        (cur.vz),
    .grad_x       (cur.gx),
    .grad_y       (cur.gy),
    .grad_z       (cur.gz),
    .scalar_a     (cur.sa),
    .scalar_b     (cur.sb),
    .scalar_c     (cur.sc),
    .is_self      (cur.self_ent),
    .last         (cur.lst),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .new_pressure (new_pressure),
    .density_error(density_error),
    .ap_value     (ap_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint fshift(longint x);
    return x >>> FRAC;
  endfunction

  function automatic longint sat32(longint x);
    if (x > S32_MAX) return S32_MAX;
    if (x < S32_MIN) return S32_MIN;
    return x;
  endfunction

  function automatic particle_item_t row(
    input logic act,
    input logic signed [DATA_W-1:0] vx, vy, vz, gx, gy, gz, sa, sb, sc,
    input logic self_ent,
    input logic lst
  );
    particle_item_t it;
    it.act = act;
    it.vx = vx;
    it.vy = vy;
    it.vz = vz;
    it.gx = gx;
    it.gy = gy;
    it.gz = gz;
    it.sa = sa;
    it.sb = sb;
    it.sc = sc;
    it.self_ent = self_ent;
    it.lst = lst;
    it.typed = 1'b0;
    it.want.pressure = '0;
    it.want.derr = '0;
    it.want.ap = '0;
    return it;
  endfunction

  function automatic particle_item_t with_result(
    input particle_item_t it,
    input logic [CFG_W-1:0] p,
    input logic signed [DATA_W-1:0] d, a
  );
    particle_item_t r;
    r = it;
    r.typed = 1'b1;
    r.want.pressure = p;
    r.want.derr = d;
    r.want.ap = a;
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick32();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return I32_LO;
          1: return I32_HI;
          2: return '0;
          3: return -32'sd1;
          default: return ONE;
        endcase
      end
      1, 2, 3, 4: return $signed(32'($urandom_range(0, 32'h0010_0000))) - 32'sh0008_0000;
      default: return $signed(32'($urandom));
    endcase
  endfunction

  task automatic pressure_predict(input particle_item_t it, output bit emits,
                                  output pressure_res_t r);
    longint v [3];
    longint g [3];
    longint dotp, contrib, nsum, dt, dt2, s, apv, e, de, num, stp, p;
    int i;
    v[0] = it.vx;
    v[1] = it.vy;
    v[2] = it.vz;
    g[0] = it.gx;
    g[1] = it.gy;
    g[2] = it.gz;
    r.pressure = '0;
    r.derr = '0;
    r.ap = '0;
    if (it.act == ACT_HEADER) begin
      for (i = 0; i < 3; i++) m_own[i] = v[i];
      m_src = it.sa;
      m_diag = it.sb;
      m_old = it.sc;
      m_sum = 0;
    end else if (!it.self_ent) begin
      dotp = 0;
      for (i = 0; i < 3; i++) dotp += fshift((m_own[i] - v[i]) * g[i]);
      dotp = sat32(dotp);
      contrib = fshift(longint'(it.sa) * dotp);
      nsum = m_sum + contrib;
      if (contrib > 0 && m_sum > 0 && nsum < 0) nsum = S64_MAX;
      if (contrib < 0 && m_sum < 0 && nsum >= 0) nsum = S64_MIN;
      m_sum = nsum;
    end
    emits = it.lst;
    if (emits) begin
      dt = longint'(m_dt);
      dt2 = fshift(dt * dt);
      if (dt2 > S32_MAX) dt2 = S32_MAX;
      s = sat32(m_sum);
      apv = sat32(fshift(dt2 * s));
      e = apv - m_src;
      if (m_rho == '0) begin
        de = e > 0 ? S32_MAX : (e < 0 ? S32_MIN : 0);
      end else begin
        de = sat32((e * (longint'(1) << FRAC)) / longint'(m_rho));
      end
      if (m_diag != 0) begin
        num = sat32(fshift(longint'(m_omega) * (m_src - apv)));
        stp = (num * (longint'(1) << FRAC)) / m_diag;
        p = m_old + stp;
      end else begin
        p = m_old;
      end
      if (p < 0) p = 0;
      if (p > S32_MAX) p = S32_MAX;
      r.pressure = CFG_W'(p);
      r.derr = DATA_W'(de);
      r.ap = DATA_W'(apv);
      m_sum = 0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_dt = TIME_STEP_RST;
      m_omega = RELAXATION_RST;
      m_rho = REST_DENSITY_RST;
      m_own[0] = 0;
      m_own[1] = 0;
      m_own[2] = 0;
      m_src = 0;
      m_diag = 0;
      m_old = 0;
      m_sum = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIME_STEP:    m_dt = cfg_data;
          REG_RELAXATION:   m_omega = cfg_data;
          REG_REST_DENSITY: m_rho = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pressure_predict(cur, mon_emits, mon_res);
        if (mon_emits) begin
          if (cur.typed) expected_pressure_q.push_back(cur.want);
          else expected_pressure_q.push_back(mon_res);
        end
        items_accepted++;
        xfer_count++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        xfer_count++;
        if (expected_pressure_q.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing expected, expected none, actual %0d %0d %0d",
                   $time, new_pressure, density_error, ap_value);
        end else begin
          mon_want = expected_pressure_q.pop_front();
          if (new_pressure !== mon_want.pressure) begin
            error_count++;
            $display("%0t: new_pressure mismatch, expected %0d actual %0d",
                     $time, mon_want.pressure, new_pressure);
          end
          if (density_error !== mon_want.derr) begin
            error_count++;
            $display("%0t: density_error mismatch, expected %0d actual %0d",
                     $time, mon_want.derr, density_error);
          end
          if (ap_value !== mon_want.ap) begin
            error_count++;
            $display("%0t: ap_value mismatch, expected %0d actual %0d",
                     $time, mon_want.ap, ap_value);
          end
        end
      end
    end
  end

  task automatic offer(input particle_item_t it);
    int target;
    cur = it;
    in_valid = 1'b1;
    target = items_accepted + 1;
    do begin
      @(negedge clk);
    end while (items_accepted < target);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
    end
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (expected_pressure_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    rx_mode_t mode;
    int k;
    bit held;
    out_ready = 1'b0;
    held = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      for (k = 0; k < 64; k++) begin
        @(negedge clk);
        if (!held && results_seen >= 40) begin
          held = 1'b1;
          out_ready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        case (mode)
          RX_OPEN:    out_ready = 1'b1;
          RX_RANDOM:  out_ready = 1'($urandom_range(0, 1));
          RX_PATTERN: out_ready = (k % 4) != 3;
          default:    out_ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin
    int idle;
    int seen;
    idle = 0;
    seen = 0;
    while (idle < IDLE_LIMIT) begin
      @(negedge clk);
      if (xfer_count != seen) begin
        seen = xfer_count;
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    particle_item_t tab [$];
    particle_item_t it;
    logic [CFG_W-1:0] dt_v, om_v, rho_v;
    int n, nterms, k, ph;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    burst_left = 1;
    gaps_on = 1'b1;
    cur = row(ACT_HEADER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Neighbour term ahead of any header works on the reset state.
    tab.push_back(row(ACT_TERM, 3 * ONE, -2 * ONE, ONE, ONE / 2, ONE, -ONE, 2 * ONE,
                      0, 0, 1'b0, 1'b1));
    tab.push_back(with_result(row(ACT_HEADER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1),
                              31'd0, 0, 0));
    // Zero diagonal keeps the old pressure, clamped at zero.
    tab.push_back(with_result(row(ACT_HEADER, 0, 0, 0, 0, 0, 0, 0, 0, 12345, 1'b0, 1'b1),
                              31'd12345, 0, 0));
    tab.push_back(with_result(row(ACT_HEADER, 0, 0, 0, 0, 0, 0, 65536000, 0, -1000,
                                  1'b0, 1'b1), 31'd0, -65536, 0));
    tab.push_back(with_result(row(ACT_HEADER, 0, 0, 0, 0, 0, 0, I32_LO, 0, I32_HI,
                                  1'b0, 1'b1), 31'h7FFF_FFFF, 2147483, 0));
    tab.push_back(row(ACT_HEADER, I32_LO, I32_HI, 0, 0, 0, 0, 1000, ONE, ONE, 1'b0, 1'b0));
    tab.push_back(row(ACT_TERM, I32_HI, I32_LO, -1, I32_LO, I32_HI, I32_HI, I32_HI,
                      0, 0, 1'b0, 1'b0));
    tab.push_back(row(ACT_TERM, ONE, ONE, ONE, ONE, ONE, ONE, ONE, 7, 9, 1'b1, 1'b0));
    tab.push_back(row(ACT_TERM, ONE / 4, -ONE, 0, ONE, ONE / 8, -ONE, ONE, 0, 0,
                      1'b0, 1'b1));
    tab.push_back(row(ACT_HEADER, ONE, 2 * ONE, -ONE, 0, 0, 0, 4 * ONE, -3 * ONE,
                      10 * ONE, 1'b0, 1'b0));
    tab.push_back(row(ACT_TERM, 0, 0, 0, ONE / 4, ONE / 2, ONE, I32_LO, 0, 0, 1'b0, 1'b0));
    tab.push_back(row(ACT_TERM, 5, 6, 7, 8, 9, 10, 11, 12, 13, 1'b1, 1'b1));
    tab.push_back(row(ACT_HEADER, 0, 0, 0, 0, 0, 0, I32_HI, I32_LO, 0, 1'b0, 1'b1));
    tab.push_back(row(ACT_HEADER, 0, 0, 0, 0, 0, 0, I32_HI, 1, ONE, 1'b0, 1'b1));
    tab.push_back(row(ACT_HEADER, 0, 0, 0, 0, 0, 0, I32_LO, -1, I32_HI, 1'b0, 1'b1));
    tab.push_back(row(ACT_HEADER, I32_HI, I32_HI, I32_HI, 3, 4, 5, ONE, ONE, ONE,
                      1'b1, 1'b0));
    tab.push_back(row(ACT_TERM, ONE, ONE, ONE, 0, 0, 0, I32_HI, -5, -6, 1'b0, 1'b0));
    tab.push_back(row(ACT_TERM, I32_LO, I32_LO, I32_LO, I32_HI, I32_HI, I32_HI, I32_LO,
                      0, 0, 1'b0, 1'b0));
    tab.push_back(row(ACT_TERM, I32_LO, I32_LO, I32_LO, I32_HI, I32_HI, I32_HI, I32_HI,
                      0, 0, 1'b0, 1'b1));
    foreach (tab[i]) offer(tab[i]);
    drain();

    for (ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: begin
          dt_v = 31'd1;
          om_v = 31'd1;
          rho_v = 31'd1;
        end
        2: begin
          dt_v = 31'h7FFF_FFFF;
          om_v = 31'h7FFF_FFFF;
          rho_v = 31'h7FFF_FFFF;
        end
        3: begin
          // A rest density of zero saturates the density error by sign.
          dt_v = 31'd6554;
          om_v = 31'd32768;
          rho_v = '0;
        end
        4: begin
          dt_v = 31'($urandom_range(1, 32'h7FFF_FFFF));
          om_v = 31'($urandom_range(1, 32'h7FFF_FFFF));
          rho_v = 31'($urandom_range(1, 32'h7FFF_FFFF));
        end
        default: begin
          dt_v = 31'd655;
          om_v = 31'd45875;
          rho_v = 31'd65536000;
        end
      endcase
      write_reg(REG_TIME_STEP, dt_v);
      write_reg(REG_RELAXATION, om_v);
      write_reg(REG_REST_DENSITY, rho_v);
      write_reg(REG_SPARE, 31'($urandom));
      gaps_on = (ph != 2);
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 15) begin
          it = row(1'($urandom_range(0, 1)), $signed(32'($urandom)), $signed(32'($urandom)),
                   $signed(32'($urandom)), $signed(32'($urandom)), $signed(32'($urandom)),
                   $signed(32'($urandom)), $signed(32'($urandom)), $signed(32'($urandom)),
                   $signed(32'($urandom)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
          offer(it);
          n++;
        end else begin
          nterms = $urandom_range(0, 6);
          it = row(ACT_HEADER, pick32(), pick32(), pick32(), $signed(32'($urandom)),
                   $signed(32'($urandom)), $signed(32'($urandom)), pick32(), pick32(),
                   pick32(), 1'($urandom_range(0, 1)), nterms == 0);
          offer(it);
          n++;
          for (k = 0; k < nterms; k++) begin
            it = row(ACT_TERM, pick32(), pick32(), pick32(), pick32(), pick32(), pick32(),
                     pick32(), $signed(32'($urandom)), $signed(32'($urandom)),
                     $urandom_range(0, 7) == 0, k == nterms - 1);
            offer(it);
            n++;
          end
        end
      end
      drain();
    end

    if (error_count == 0 && expected_pressure_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
